@@ design/mpq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants of the MPQ block cipher: the key table, its
// generator, and the structs that pass between the cipher's modules.
// ----------------------------------------------------------------------------
package mpq_pkg;

    // Key table geometry.
    localparam int TBL_DEPTH = 256;
    localparam int TBL_AW    = 8;
    localparam int WORD_W    = 32;

    // Direction register codes.
    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    // Cipher constants.
    localparam logic [31:0] SEED_INIT = 32'hEEEE_EEEE;
    localparam logic [31:0] KEY_ADD   = 32'h1111_1111;
    localparam logic [31:0] SEED_ADD  = 32'd3;

    // Table generator constants.
    localparam logic [31:0] GEN_INIT  = 32'h0010_0001;
    localparam logic [31:0] GEN_MOD   = 32'h002A_AAAB;
    localparam logic [31:0] GEN_MUL   = 32'd125;
    localparam logic [31:0] GEN_ADD   = 32'd3;
    localparam int          GEN_TABS  = 5;

    typedef logic [TBL_DEPTH-1:0][WORD_W-1:0] t_tbl;

    // Builds the fifth of the five generator tables; evaluated at elaboration.
    function automatic t_tbl build_key_table();
        t_tbl        tbl;
        logic [31:0] s;
        logic [15:0] hi;
        tbl = '0;
        s   = GEN_INIT;
        for (int row = 0; row < TBL_DEPTH; row++) begin
            for (int tab = 0; tab < GEN_TABS; tab++) begin
                s  = (GEN_MUL * s + GEN_ADD) % GEN_MOD;
                hi = s[15:0];
                s  = (GEN_MUL * s + GEN_ADD) % GEN_MOD;
                if (tab == GEN_TABS - 1) begin
                    tbl[row] = {hi, s[15:0]};
                end
            end
        end
        return tbl;
    endfunction

    localparam t_tbl KEY_TABLE = build_key_table();

    // Write port of the table load sweep.
    typedef struct packed {
        logic              we;
        logic [TBL_AW-1:0] addr;
        logic [WORD_W-1:0] data;
        logic              done;
    } t_fill_port;

    // One word held in the seed stage.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] key;
        logic              start;
        logic              last;
    } t_s1_item;

endpackage
`default_nettype wire

@@ design/mpq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_ram
// Generic single-write, single-read synchronous RAM with a registered read
// port. The read data holds while no read is issued.
// ----------------------------------------------------------------------------
module mpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ design/mpq_fill.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_fill
// Load sweep that copies the constant key table into the table RAM after
// reset, one entry per cycle, and then reports done.
// ----------------------------------------------------------------------------
module mpq_fill (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    output mpq_pkg::t_fill_port      o_fill
);

    logic [mpq_pkg::TBL_AW:0] r_cnt;
    logic [mpq_pkg::TBL_AW:0] n_cnt;

    // The top bit of the counter sets once every entry has been written.
    always_comb begin
        n_cnt = r_cnt;
        if (!r_cnt[mpq_pkg::TBL_AW]) begin
            n_cnt = r_cnt + {{mpq_pkg::TBL_AW{1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_fill.we   = !r_cnt[mpq_pkg::TBL_AW];
    assign o_fill.addr = r_cnt[mpq_pkg::TBL_AW-1:0];
    assign o_fill.data = mpq_pkg::KEY_TABLE[r_cnt[mpq_pkg::TBL_AW-1:0]];
    assign o_fill.done = r_cnt[mpq_pkg::TBL_AW];

endmodule
`default_nettype wire

@@ design/mpq_seed_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_seed_unit
// Seed stage of the cipher: mixes the table word into the running seed,
// forms the result word and absorbs the plaintext word into the seed.
// ----------------------------------------------------------------------------
module mpq_seed_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire mpq_pkg::t_s1_item             i_item,
    input  wire logic [mpq_pkg::WORD_W-1:0]    i_tbl,
    input  wire logic                          i_dir,
    output logic      [mpq_pkg::WORD_W-1:0]    o_result
);

    logic [mpq_pkg::WORD_W-1:0] r_seed;
    logic [mpq_pkg::WORD_W-1:0] n_seed;
    logic [mpq_pkg::WORD_W-1:0] seed_mix;
    logic [mpq_pkg::WORD_W-1:0] result;
    logic [mpq_pkg::WORD_W-1:0] plain;

    // A start word restarts the seed chain.
    always_comb begin
        seed_mix = (i_item.start ? mpq_pkg::SEED_INIT : r_seed) + i_tbl;
        result   = i_item.word ^ (seed_mix + i_item.key);
        plain    = (i_dir == mpq_pkg::DIR_DECRYPT) ? result : i_item.word;
        n_seed   = seed_mix + plain + {seed_mix[mpq_pkg::WORD_W-6:0], 5'd0}
                   + mpq_pkg::SEED_ADD;
    end

    // The seed moves on when the word leaves this stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= mpq_pkg::SEED_INIT;
        end else if (i_adv) begin
            r_seed <= n_seed;
        end
    end

    assign o_result = result;

endmodule
`default_nettype wire

@@ design/mpq_block_cipher.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_block_cipher
// Streaming MPQ block cipher, one 32-bit word per transaction.
// ----------------------------------------------------------------------------
// After reset the block loads its key table RAM, holding s_axis_tready low;
// configuration writes are taken throughout. It then accepts one word per
// cycle while the output is not stalled, passing each word through the seed
// stage register and the output register. The key schedule runs in the
// accept cycle and issues the table RAM read for the word; the seed update
// (table add, result add and plaintext absorb) is combinational in the seed
// stage, which sets the one-word-per-cycle rate. The output register decouples
// the two sides, so one word can sit in the seed stage while a finished result
// waits to be taken. Direction (0 encrypt, 1 decrypt) resets to decrypt; the
// user must write it through i_cfg_we while the block is idle (unenforced).
// ----------------------------------------------------------------------------
module mpq_block_cipher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration.
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,     // direction
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,    // [31:0] data_word, [63:32] block_key
    input  wire logic        s_axis_tuser,    // [0] start_of_block
    input  wire logic        s_axis_tlast,    // end_of_block
    // Output stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,    // [31:0] result_word
    output logic             m_axis_tlast     // last_word
);

    mpq_pkg::t_fill_port         fill;
    mpq_pkg::t_s1_item           r_s1;
    logic                        r_s1_valid;
    logic                        r_dir;
    logic [mpq_pkg::WORD_W-1:0]  r_key;
    logic [mpq_pkg::WORD_W-1:0]  cur_key;
    logic [mpq_pkg::WORD_W-1:0]  n_key;
    logic [mpq_pkg::WORD_W-1:0]  tbl_word;
    logic [mpq_pkg::WORD_W-1:0]  s1_result;
    logic                        in_acc;
    logic                        s1_adv;
    logic                        r_out_valid;
    logic [mpq_pkg::WORD_W-1:0]  r_out_word;
    logic                        r_out_last;

    // Table load sweep and table RAM.
    mpq_fill u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_fill  (fill)
    );

    mpq_ram #(
        .WIDTH (mpq_pkg::WORD_W),
        .DEPTH (mpq_pkg::TBL_DEPTH)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (fill.we),
        .i_waddr (fill.addr),
        .i_wdata (fill.data),
        .i_re    (in_acc),
        .i_raddr (cur_key[mpq_pkg::TBL_AW-1:0]),
        .o_rdata (tbl_word)
    );

    // Handshake: the seed stage moves when the output register is free.
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = fill.done && (!r_s1_valid || s1_adv);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Key schedule for the accepted word.
    always_comb begin
        cur_key = s_axis_tuser ? s_axis_tdata[63:32] : r_key;
        n_key   = (({~cur_key[mpq_pkg::WORD_W-22:0], 21'd0}) + mpq_pkg::KEY_ADD)
                  | {11'd0, cur_key[mpq_pkg::WORD_W-1:11]};
    end

    // Direction register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= mpq_pkg::DIR_DECRYPT;
        end else if (i_cfg_we) begin
            r_dir <= i_cfg_wdata;
        end
    end

    // Running key and seed stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_key      <= n_key;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Seed stage payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1.word  <= s_axis_tdata[31:0];
            r_s1.key   <= cur_key;
            r_s1.start <= s_axis_tuser;
            r_s1.last  <= s_axis_tlast;
        end
    end

    mpq_seed_unit u_seed (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (s1_adv),
        .i_item   (r_s1),
        .i_tbl    (tbl_word),
        .i_dir    (r_dir),
        .o_result (s1_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_word <= s1_result;
            r_out_last <= r_s1.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;
    assign m_axis_tlast  = r_out_last;

    // No word is taken while the table is still loading.
    a_no_accept_in_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fill.done |-> !s_axis_tready)
        else $error("input accepted during table load");

    // A word held in the seed stage only waits behind a full output register.
    a_s1_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> (r_out_valid && !m_axis_tready))
        else $error("seed stage stalled without output backpressure");

    // An accepted word occupies the seed stage in the next cycle.
    a_accept_fills_s1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted word lost before seed stage");

    // The running key follows the schedule of the accepted word.
    a_key_schedule : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_key == $past(n_key)))
        else $error("running key does not follow key schedule");

endmodule
`default_nettype wire
